/* hw/rtl/cbb_pkg.sv */
// shared types and constants for the color blob bounding box tracker
package cbb_pkg;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // register widths
    localparam int LINE_W_W  = 11;
    localparam int HITS_W    = 21;
    localparam int FLOOR_W   = 5;
    localparam int RG_MARG_W = 7;
    localparam int RB_MARG_W = 5;

    // result position width
    localparam int POS_W = 10;

    // rgb565 layout
    localparam int PIXEL_W = 16;
    localparam int RED_W   = 5;
    localparam int GREEN_W = 6;
    localparam int BLUE_W  = 5;
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 5;
    localparam int BLUE_LSB  = 0;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // register reset values
    localparam logic [LINE_W_W-1:0]  LINE_W_RST    = LINE_W_W'(220);
    localparam logic [HITS_W-1:0]    MIN_COUNT_RST = HITS_W'(300);
    localparam logic [FLOOR_W-1:0]   FLOOR_RST     = FLOOR_W'(15);
    localparam logic [RG_MARG_W-1:0] RG_MARG_RST   = RG_MARG_W'(12);
    localparam logic [RB_MARG_W-1:0] RB_MARG_RST   = RB_MARG_W'(6);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH = 3'd0,
        CFG_MIN_COUNT  = 3'd1,
        CFG_RED_FLOOR  = 3'd2,
        CFG_RG_MARGIN  = 3'd3,
        CFG_RB_MARGIN  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  mid_x;
        logic [POS_W-1:0]  mid_y;
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  right;
        logic [POS_W-1:0]  top;
        logic [POS_W-1:0]  bottom;
        logic [HITS_W-1:0] hit_count;
    } t_blob_result;

endpackage

/* hw/rtl/cbb_classify.sv */
// color threshold test of one rgb565 pixel
module cbb_classify (
    input  logic [cbb_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic [cbb_pkg::FLOOR_W-1:0]   i_red_floor,
    input  logic [cbb_pkg::RG_MARG_W-1:0] i_rg_margin,
    input  logic [cbb_pkg::RB_MARG_W-1:0] i_rb_margin,
    output logic                          o_hit
);

    logic [cbb_pkg::RED_W-1:0]   red;
    logic [cbb_pkg::GREEN_W-1:0] green;
    logic [cbb_pkg::BLUE_W-1:0]  blue;
    logic signed [8:0]           rg_diff;
    logic signed [6:0]           rb_diff;

    assign red   = i_pixel[cbb_pkg::RED_LSB   +: cbb_pkg::RED_W];
    assign green = i_pixel[cbb_pkg::GREEN_LSB +: cbb_pkg::GREEN_W];
    assign blue  = i_pixel[cbb_pkg::BLUE_LSB  +: cbb_pkg::BLUE_W];

    // 2r - g and r - b as exact signed values
    assign rg_diff = $signed({3'b000, red, 1'b0}) - $signed({3'b000, green});
    assign rb_diff = $signed({2'b00, red}) - $signed({2'b00, blue});

    assign o_hit = (red > i_red_floor)
                && (rg_diff > $signed({2'b00, i_rg_margin}))
                && (rb_diff > $signed({2'b00, i_rb_margin}));

endmodule

/* hw/rtl/cbb_accum.sv */
// frame state: raster counters, hit count and bounding box, result forming
module cbb_accum #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int MAX_ROWS       = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_hit,
    input  logic                          i_frame_end,
    input  logic [cbb_pkg::LINE_W_W-1:0]  i_line_width,
    input  logic [cbb_pkg::HITS_W-1:0]    i_min_count,
    output cbb_pkg::t_blob_result         o_result
);

    localparam int CW   = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int RW   = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
    localparam int WCMP = ($clog2(MAX_LINE_WIDTH + 1) > cbb_pkg::LINE_W_W)
                          ? $clog2(MAX_LINE_WIDTH + 1) : cbb_pkg::LINE_W_W;
    localparam int XW   = ((CW > RW ? CW : RW) > cbb_pkg::POS_W
                          ? (CW > RW ? CW : RW) : cbb_pkg::POS_W) + 1;

    localparam logic [WCMP-1:0] WIDTH_MAX = WCMP'(MAX_LINE_WIDTH);
    localparam logic [RW-1:0]   ROW_LAST  = RW'(MAX_ROWS - 1);

    logic [CW-1:0]             r_column, n_column;
    logic [RW-1:0]             r_row, n_row;
    logic [cbb_pkg::HITS_W-1:0] r_hits, n_hits;
    logic [CW-1:0]             r_left, n_left, r_right, n_right;
    logic [RW-1:0]             r_top, n_top, r_bottom, n_bottom;
    logic                      r_any, n_any;

    logic [cbb_pkg::HITS_W-1:0] upd_hits;
    logic [CW-1:0]             upd_left, upd_right;
    logic [RW-1:0]             upd_top, upd_bottom;
    logic                      upd_any;
    logic [WCMP-1:0]           width_raw, width_eff, col_plus;
    logic [XW-1:0]             l_ext, r_ext, t_ext, b_ext, sum_x, sum_y;

    // fold the current pixel into count and box
    always_comb begin
        upd_hits   = r_hits;
        upd_left   = r_left;
        upd_right  = r_right;
        upd_top    = r_top;
        upd_bottom = r_bottom;
        upd_any    = r_any;
        if (i_hit) begin
            if (r_hits != cbb_pkg::HITS_MAX) begin
                upd_hits = r_hits + 1'b1;
            end
            upd_any = 1'b1;
            if (!r_any) begin
                upd_left   = r_column;
                upd_right  = r_column;
                upd_top    = r_row;
                upd_bottom = r_row;
            end else begin
                if (r_column < r_left)   upd_left   = r_column;
                if (r_column > r_right)  upd_right  = r_column;
                if (r_row < r_top)       upd_top    = r_row;
                if (r_row > r_bottom)    upd_bottom = r_row;
            end
        end
    end

    // effective line width, clamped to 1..max
    always_comb begin
        width_raw = WCMP'(i_line_width);
        if (width_raw == '0) begin
            width_eff = WCMP'(1);
        end else if (width_raw > WIDTH_MAX) begin
            width_eff = WIDTH_MAX;
        end else begin
            width_eff = width_raw;
        end
        col_plus = WCMP'(r_column) + WCMP'(1);
    end

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        n_hits   = r_hits;
        n_left   = r_left;
        n_right  = r_right;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_any    = r_any;
        if (i_en) begin
            if (i_frame_end) begin
                n_column = '0;
                n_row    = '0;
                n_hits   = '0;
                n_left   = '0;
                n_right  = '0;
                n_top    = '0;
                n_bottom = '0;
                n_any    = 1'b0;
            end else begin
                n_hits   = upd_hits;
                n_left   = upd_left;
                n_right  = upd_right;
                n_top    = upd_top;
                n_bottom = upd_bottom;
                n_any    = upd_any;
                // column at or past the width wraps, even after a width change
                if (col_plus >= width_eff) begin
                    n_column = '0;
                    if (r_row != ROW_LAST) begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_column = col_plus[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_hits   <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_top    <= '0;
            r_bottom <= '0;
            r_any    <= 1'b0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
            r_hits   <= n_hits;
            r_left   <= n_left;
            r_right  <= n_right;
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_any    <= n_any;
        end
    end

    // result of the frame including the current pixel
    always_comb begin
        l_ext = XW'(upd_left);
        r_ext = XW'(upd_right);
        t_ext = XW'(upd_top);
        b_ext = XW'(upd_bottom);
        sum_x = l_ext + r_ext;
        sum_y = t_ext + b_ext;
        o_result.found     = (upd_hits > i_min_count);
        o_result.mid_x     = sum_x[cbb_pkg::POS_W:1];
        o_result.mid_y     = sum_y[cbb_pkg::POS_W:1];
        o_result.left      = l_ext[cbb_pkg::POS_W-1:0];
        o_result.right     = r_ext[cbb_pkg::POS_W-1:0];
        o_result.top       = t_ext[cbb_pkg::POS_W-1:0];
        o_result.bottom    = b_ext[cbb_pkg::POS_W-1:0];
        o_result.hit_count = upd_hits;
    end

endmodule

/* hw/rtl/color_blob_bounding_box_top.sv */
// Color blob bounding box tracker. Takes RGB565 pixels in raster order, one request per cycle
// while o_stall is low, classifies each against red/green/blue thresholds and keeps the hit
// count and bounding box; the request flagged frame_end produces one result (found, box,
// center, count) and clears the frame state. Pixels go through an input register and a
// combinational classify/update stage into the output register; sustained throughput is one
// pixel per cycle unless stalled. The output register frees the input side: pixels keep flowing
// while a result waits, and only a following frame_end pixel holds until that result is taken.
// Configuration writes are meant for idle periods between frames.
module color_blob_bounding_box_top #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int MAX_ROWS       = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [cbb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [cbb_pkg::PIXEL_W-1:0]      i_pixel,
    input  logic                             i_frame_end,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_found,
    output logic [cbb_pkg::POS_W-1:0]        o_mid_x,
    output logic [cbb_pkg::POS_W-1:0]        o_mid_y,
    output logic [cbb_pkg::POS_W-1:0]        o_left,
    output logic [cbb_pkg::POS_W-1:0]        o_right,
    output logic [cbb_pkg::POS_W-1:0]        o_top,
    output logic [cbb_pkg::POS_W-1:0]        o_bottom,
    output logic [cbb_pkg::HITS_W-1:0]       o_hit_count
);

    logic [cbb_pkg::LINE_W_W-1:0]  r_line_width;
    logic [cbb_pkg::HITS_W-1:0]    r_min_count;
    logic [cbb_pkg::FLOOR_W-1:0]   r_red_floor;
    logic [cbb_pkg::RG_MARG_W-1:0] r_rg_margin;
    logic [cbb_pkg::RB_MARG_W-1:0] r_rb_margin;

    logic                          r_s1_valid;
    logic [cbb_pkg::PIXEL_W-1:0]   r_s1_pixel;
    logic                          r_s1_frame_end;
    logic                          r_out_valid;
    cbb_pkg::t_blob_result         r_out;

    logic                          in_acc;
    logic                          s1_block;
    logic                          s1_adv;
    logic                          hit;
    cbb_pkg::t_blob_result         result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= cbb_pkg::LINE_W_RST;
            r_min_count  <= cbb_pkg::MIN_COUNT_RST;
            r_red_floor  <= cbb_pkg::FLOOR_RST;
            r_rg_margin  <= cbb_pkg::RG_MARG_RST;
            r_rb_margin  <= cbb_pkg::RB_MARG_RST;
        end else if (i_cfg_wr_en) begin
            case (cbb_pkg::t_cfg_idx'(i_cfg_idx))
                cbb_pkg::CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_wdata[cbb_pkg::LINE_W_W-1:0];
                end
                cbb_pkg::CFG_MIN_COUNT: begin
                    r_min_count <= i_cfg_wdata[cbb_pkg::HITS_W-1:0];
                end
                cbb_pkg::CFG_RED_FLOOR: begin
                    r_red_floor <= i_cfg_wdata[cbb_pkg::FLOOR_W-1:0];
                end
                cbb_pkg::CFG_RG_MARGIN: begin
                    r_rg_margin <= i_cfg_wdata[cbb_pkg::RG_MARG_W-1:0];
                end
                cbb_pkg::CFG_RB_MARGIN: begin
                    r_rb_margin <= i_cfg_wdata[cbb_pkg::RB_MARG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a frame_end pixel waits only while the previous result is still held
    assign s1_block = r_s1_frame_end && r_out_valid && i_stall;
    assign s1_adv   = r_s1_valid && !s1_block;
    assign o_stall  = r_s1_valid && s1_block;
    assign in_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pixel     <= i_pixel;
            r_s1_frame_end <= i_frame_end;
        end
    end

    cbb_classify u_classify (
        .i_pixel     (r_s1_pixel),
        .i_red_floor (r_red_floor),
        .i_rg_margin (r_rg_margin),
        .i_rb_margin (r_rb_margin),
        .o_hit       (hit)
    );

    cbb_accum #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .MAX_ROWS       (MAX_ROWS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (s1_adv),
        .i_hit        (hit),
        .i_frame_end  (r_s1_frame_end),
        .i_line_width (r_line_width),
        .i_min_count  (r_min_count),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_frame_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_frame_end) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_out.found;
    assign o_mid_x     = r_out.mid_x;
    assign o_mid_y     = r_out.mid_y;
    assign o_left      = r_out.left;
    assign o_right     = r_out.right;
    assign o_top       = r_out.top;
    assign o_bottom    = r_out.bottom;
    assign o_hit_count = r_out.hit_count;

endmodule

/* hw/rtl/cbb_checker.sv */
// port-level checks for the color blob bounding box tracker, bound to the top level
module cbb_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [cbb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_valid,
    input  logic                             o_stall,
    input  logic [cbb_pkg::PIXEL_W-1:0]      i_pixel,
    input  logic                             i_frame_end,
    input  logic                             o_valid,
    input  logic                             i_stall,
    input  logic                             o_found,
    input  logic [cbb_pkg::POS_W-1:0]        o_mid_x,
    input  logic [cbb_pkg::POS_W-1:0]        o_mid_y,
    input  logic [cbb_pkg::POS_W-1:0]        o_left,
    input  logic [cbb_pkg::POS_W-1:0]        o_right,
    input  logic [cbb_pkg::POS_W-1:0]        o_top,
    input  logic [cbb_pkg::POS_W-1:0]        o_bottom,
    input  logic [cbb_pkg::HITS_W-1:0]       o_hit_count
);

    // input side only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // a new result needs an accepted frame_end request
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_frame_end, 2))
        else $error("result without a frame_end request");

    // an empty frame reports an empty box and not found
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hit_count == '0)) |->
            (!o_found && (o_left == '0) && (o_right == '0) && (o_top == '0)
             && (o_bottom == '0) && (o_mid_x == '0) && (o_mid_y == '0)))
        else $error("empty frame with nonzero box");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_hit_count) && $stable(o_left) && $stable(o_found)))
        else $error("stalled result changed");

endmodule

bind color_blob_bounding_box_top cbb_checker u_cbb_checker (.*);
